// ===== rtl/chip8_instruction_core_defines.svh =====
// assertion helpers shared by the core
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define CIC_ASSERT_IMP(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define CIC_ASSERT_NXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/cic_pkg.sv =====
package cic_pkg;

    // geometry
    localparam int AW            = 12;
    localparam int MEM_BYTES     = 4096;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH);
    localparam int SC_W          = $clog2(STACK_DEPTH + 1);
    localparam int NREGS         = 16;
    localparam int RI_W          = $clog2(NREGS);

    localparam logic [AW-1:0] PROG_START = 12'h200;
    localparam logic [AW-1:0] FONT_BASE  = 12'h050;

    // item operations
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_EXEC  = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_PIXEL = 3'd4;

    // instruction groups (top nibble)
    localparam logic [3:0] OPC_SYS  = 4'h0;
    localparam logic [3:0] OPC_JP   = 4'h1;
    localparam logic [3:0] OPC_CALL = 4'h2;
    localparam logic [3:0] OPC_SEI  = 4'h3;
    localparam logic [3:0] OPC_SNEI = 4'h4;
    localparam logic [3:0] OPC_SER  = 4'h5;
    localparam logic [3:0] OPC_LDI  = 4'h6;
    localparam logic [3:0] OPC_ADDI = 4'h7;
    localparam logic [3:0] OPC_ALU  = 4'h8;
    localparam logic [3:0] OPC_SNER = 4'h9;
    localparam logic [3:0] OPC_LDIX = 4'hA;
    localparam logic [3:0] OPC_JPV0 = 4'hB;
    localparam logic [3:0] OPC_RND  = 4'hC;
    localparam logic [3:0] OPC_DRW  = 4'hD;
    localparam logic [3:0] OPC_KEY  = 4'hE;
    localparam logic [3:0] OPC_MISC = 4'hF;

    localparam logic [15:0] W_CLS = 16'h00E0;
    localparam logic [15:0] W_RET = 16'h00EE;

    // alu functions
    localparam logic [3:0] AL_MOV = 4'h0;
    localparam logic [3:0] AL_OR  = 4'h1;
    localparam logic [3:0] AL_AND = 4'h2;
    localparam logic [3:0] AL_XOR = 4'h3;
    localparam logic [3:0] AL_ADD = 4'h4;
    localparam logic [3:0] AL_SUB = 4'h5;
    localparam logic [3:0] AL_SHR = 4'h6;
    localparam logic [3:0] AL_SBN = 4'h7;
    localparam logic [3:0] AL_SHL = 4'hE;

    // key and misc functions
    localparam logic [7:0] FN_SKP  = 8'h9E;
    localparam logic [7:0] FN_SKNP = 8'hA1;
    localparam logic [7:0] FN_GDT  = 8'h07;
    localparam logic [7:0] FN_WKEY = 8'h0A;
    localparam logic [7:0] FN_SDT  = 8'h15;
    localparam logic [7:0] FN_SST  = 8'h18;
    localparam logic [7:0] FN_ADDI = 8'h1E;
    localparam logic [7:0] FN_FONT = 8'h29;
    localparam logic [7:0] FN_BCD  = 8'h33;
    localparam logic [7:0] FN_STR  = 8'h55;
    localparam logic [7:0] FN_LDR  = 8'h65;

    localparam logic [3:0] BCD_LAST = 4'd2;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_DISPATCH, ST_HOST_RD, ST_FETCH_LO, ST_DECODE,
        ST_EXEC, ST_FLAG, ST_SPR_RD, ST_SPR_WR, ST_BCD, ST_ST_RD, ST_ST_WR,
        ST_LD_RD, ST_LD_WR, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        K_BASIC, K_FLAG, K_DRAW, K_BCD, K_STORE, K_LOAD
    } t_kind;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [15:0] keys;
        logic [7:0]  random_byte;
    } t_in_item;

    typedef struct packed {
        logic [11:0] pc_now;
        logic [15:0] executed_opcode;
        logic        draw_request;
        logic        sound_on;
        logic        waiting_key;
        logic        fault;
        logic [7:0]  read_data;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic init_wr;
        logic host_wr;
        logic tick;
        logic host_mem_rd;
        logic host_pix_rd;
        logic host_cap;
        logic fetch_hi;
        logic fetch_lo;
        logic cap_op;
        logic exec;
        logic flag_wr;
        logic spr_rd;
        logic spr_wr;
        logic spr_end;
        logic bcd_wr;
        logic st_rd;
        logic st_wr;
        logic ld_rd;
        logic ld_wr;
        logic cnt_clr;
        logic cnt_inc;
        logic finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0]      op;
        logic            halted;
        t_kind           kind;
        logic            init_last;
        logic            spr_done;
        logic            last_x;
        logic            last_bcd;
        logic [SC_W-1:0] sc;
    } t_stat;

endpackage

// ===== rtl/cic_chan_if.sv =====
// input item channel
interface cic_in_if;
    import cic_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  random_byte;

    modport source (output valid, op, addr, data, keys, random_byte, input ready);
    modport sink   (input valid, op, addr, data, keys, random_byte, output ready);
endinterface

// result channel
interface cic_out_if;
    import cic_pkg::*;
    logic        valid;
    logic        ready;
    logic [11:0] pc_now;
    logic [15:0] executed_opcode;
    logic        draw_request;
    logic        sound_on;
    logic        waiting_key;
    logic        fault;
    logic [7:0]  read_data;

    modport source (output valid, pc_now, executed_opcode, draw_request, sound_on,
                    waiting_key, fault, read_data, input ready);
    modport sink   (input valid, pc_now, executed_opcode, draw_request, sound_on,
                    waiting_key, fault, read_data, output ready);
endinterface

// ===== rtl/cic_ctrl.sv =====
module cic_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  cic_pkg::t_stat i_stat,
    output cic_pkg::t_cmd  o_cmd
);
    import cic_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // result register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_stat.op)
                    OP_WRITE: begin
                        o_cmd.host_wr = 1'b1;
                        n_state       = ST_OUT;
                    end
                    OP_TICK: begin
                        o_cmd.tick = 1'b1;
                        n_state    = ST_OUT;
                    end
                    OP_READ: begin
                        o_cmd.host_mem_rd = 1'b1;
                        n_state           = ST_HOST_RD;
                    end
                    OP_PIXEL: begin
                        o_cmd.host_pix_rd = 1'b1;
                        n_state           = ST_HOST_RD;
                    end
                    OP_EXEC: begin
                        if (i_stat.halted) begin
                            n_state = ST_OUT;
                        end else begin
                            o_cmd.fetch_hi = 1'b1;
                            n_state        = ST_FETCH_LO;
                        end
                    end
                    default: begin
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_HOST_RD: begin
                o_cmd.host_cap = 1'b1;
                n_state        = ST_OUT;
            end
            ST_FETCH_LO: begin
                o_cmd.fetch_lo = 1'b1;
                n_state        = ST_DECODE;
            end
            ST_DECODE: begin
                o_cmd.cap_op = 1'b1;
                n_state      = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (i_stat.kind)
                    K_BASIC: begin
                        o_cmd.exec = 1'b1;
                        n_state    = ST_OUT;
                    end
                    K_FLAG: begin
                        o_cmd.exec = 1'b1;
                        n_state    = ST_FLAG;
                    end
                    K_DRAW: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = ST_SPR_RD;
                    end
                    K_BCD: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = ST_BCD;
                    end
                    K_STORE: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = ST_ST_RD;
                    end
                    K_LOAD: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = ST_LD_RD;
                    end
                    default: begin
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_FLAG: begin
                o_cmd.flag_wr = 1'b1;
                n_state       = ST_OUT;
            end
            // sprite: one row per read and write pair
            ST_SPR_RD: begin
                if (i_stat.spr_done) begin
                    o_cmd.spr_end = 1'b1;
                    o_cmd.finish  = 1'b1;
                    n_state       = ST_OUT;
                end else begin
                    o_cmd.spr_rd = 1'b1;
                    n_state      = ST_SPR_WR;
                end
            end
            ST_SPR_WR: begin
                o_cmd.spr_wr  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = ST_SPR_RD;
            end
            ST_BCD: begin
                o_cmd.bcd_wr = 1'b1;
                if (i_stat.last_bcd) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_OUT;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            ST_ST_RD: begin
                o_cmd.st_rd = 1'b1;
                n_state     = ST_ST_WR;
            end
            ST_ST_WR: begin
                o_cmd.st_wr = 1'b1;
                if (i_stat.last_x) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_OUT;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = ST_ST_RD;
                end
            end
            ST_LD_RD: begin
                o_cmd.ld_rd = 1'b1;
                n_state     = ST_LD_WR;
            end
            ST_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                if (i_stat.last_x) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_OUT;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = ST_LD_RD;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cic_dpath.sv =====
module cic_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cic_pkg::t_cmd      i_cmd,
    input  cic_pkg::t_in_item  i_item,
    output cic_pkg::t_stat     o_stat,
    output cic_pkg::t_out_item o_res
);
    import cic_pkg::*;

    localparam int FONT_BYTES = 80;
    localparam int FI_W       = $clog2(FONT_BYTES);
    localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // reset image of main memory
    function automatic logic [7:0] font_at(input logic [AW-1:0] a);
        logic [AW-1:0] off;
        off = a - FONT_BASE;
        if (a >= FONT_BASE && off < AW'(FONT_BYTES)) begin
            font_at = GLYPHS[off[FI_W-1:0]];
        end else begin
            font_at = 8'd0;
        end
    endfunction

    // one decimal digit of a byte, sel 0 hundreds, 1 tens, 2 ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] a, input logic [3:0] sel);
        logic [7:0] h, r, t, o;
        h = (a >= 8'd200) ? 8'd2 : ((a >= 8'd100) ? 8'd1 : 8'd0);
        r = a - ((a >= 8'd200) ? 8'd200 : ((a >= 8'd100) ? 8'd100 : 8'd0));
        t = 8'd0;
        for (int k = 1; k < 10; k++) begin
            if (r >= 8'(10 * k)) begin
                t = 8'(k);
            end
        end
        o = r - 8'((t << 3) + (t << 1));
        if (sel == 4'd0) begin
            bcd_digit = h;
        end else if (sel == 4'd1) begin
            bcd_digit = t;
        end else begin
            bcd_digit = o;
        end
    endfunction

    // storage
    logic [7:0]              mem [MEM_BYTES];
    logic [SCREEN_WIDTH-1:0] frame [SCREEN_HEIGHT];
    logic [7:0]              regs [NREGS];
    logic [AW-1:0]           stack [STACK_DEPTH];

    // architectural and sequencing registers
    t_in_item           r_item;
    t_out_item          r_out;
    logic [AW-1:0]      r_pc, r_i, r_init;
    logic [7:0]         r_dt, r_st;
    logic               r_halted;
    logic [SC_W-1:0]    r_sc;
    logic [15:0]        r_word;
    logic               r_drew, r_wait, r_hit, r_flag;
    logic [7:0]         r_rd;
    logic [3:0]         r_cnt;
    logic [7:0]         r_ra, r_rb, r_mem_q;
    logic [SCREEN_WIDTH-1:0]  r_frame_q;
    logic               r_frame_v;
    logic [SCREEN_HEIGHT-1:0] r_row_vld;
    logic [NREGS-1:0]   r_reg_vld;

    // instruction fields
    logic [3:0]    w_top, w_x, w_n;
    logic [7:0]    w_kk;
    logic [AW-1:0] w_nnn, w_next, w_skip, w_i_cnt;
    logic [SC_W-1:0] w_sc_dec;
    logic          w_key_dn;
    logic [3:0]    w_key_idx;
    logic [8:0]    w_sum;
    t_kind         w_kind;

    assign w_top   = r_word[15:12];
    assign w_x     = r_word[11:8];
    assign w_n     = r_word[3:0];
    assign w_kk    = r_word[7:0];
    assign w_nnn   = r_word[11:0];
    assign w_next  = r_pc + 12'd2;
    assign w_skip  = r_pc + 12'd4;
    assign w_i_cnt = r_i + AW'(r_cnt);
    assign w_sc_dec = r_sc - SC_W'(1);
    assign w_key_dn = (r_ra[7:4] == 4'd0) && r_item.keys[r_ra[3:0]];
    assign w_sum   = {1'b0, r_ra} + {1'b0, r_rb};

    // lowest pressed key
    always_comb begin
        w_key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_item.keys[k]) begin
                w_key_idx = 4'(k);
            end
        end
    end

    // instruction class for sequencing
    always_comb begin
        w_kind = K_BASIC;
        if (w_top == OPC_ALU) begin
            if (w_n == AL_ADD || w_n == AL_SUB || w_n == AL_SHR || w_n == AL_SBN ||
                w_n == AL_SHL) begin
                w_kind = K_FLAG;
            end
        end else if (w_top == OPC_DRW) begin
            w_kind = K_DRAW;
        end else if (w_top == OPC_MISC) begin
            if (w_kk == FN_BCD) begin
                w_kind = K_BCD;
            end else if (w_kk == FN_STR) begin
                w_kind = K_STORE;
            end else if (w_kk == FN_LDR) begin
                w_kind = K_LOAD;
            end
        end
    end

    // single-step execute
    logic [AW-1:0] e_pc, e_i;
    logic [7:0]    e_vx;
    logic          e_vx_we, e_flag, e_i_we, e_dt_we, e_st_we;
    logic          e_push, e_pop, e_cls, e_fault, e_wait;

    always_comb begin
        e_pc    = w_next;
        e_i     = r_i;
        e_vx    = r_ra;
        e_vx_we = 1'b0;
        e_flag  = 1'b0;
        e_i_we  = 1'b0;
        e_dt_we = 1'b0;
        e_st_we = 1'b0;
        e_push  = 1'b0;
        e_pop   = 1'b0;
        e_cls   = 1'b0;
        e_fault = 1'b0;
        e_wait  = 1'b0;
        unique case (w_top)
            OPC_SYS: begin
                if (r_word == W_CLS) begin
                    e_cls = 1'b1;
                end else if (r_word == W_RET && r_sc != '0) begin
                    e_pop = 1'b1;
                    e_pc  = stack[w_sc_dec[SP_W-1:0]];
                end
            end
            OPC_JP: e_pc = w_nnn;
            OPC_CALL: begin
                if (r_sc == SC_W'(STACK_DEPTH)) begin
                    e_fault = 1'b1;
                end else begin
                    e_push = 1'b1;
                    e_pc   = w_nnn;
                end
            end
            OPC_SEI:  e_pc = (r_ra == w_kk) ? w_skip : w_next;
            OPC_SNEI: e_pc = (r_ra != w_kk) ? w_skip : w_next;
            OPC_SER: begin
                if (w_n != 4'd0) begin
                    e_fault = 1'b1;
                end else begin
                    e_pc = (r_ra == r_rb) ? w_skip : w_next;
                end
            end
            OPC_LDI: begin
                e_vx    = w_kk;
                e_vx_we = 1'b1;
            end
            OPC_ADDI: begin
                e_vx    = r_ra + w_kk;
                e_vx_we = 1'b1;
            end
            OPC_ALU: begin
                e_vx_we = 1'b1;
                unique case (w_n)
                    AL_MOV: e_vx = r_rb;
                    AL_OR:  e_vx = r_ra | r_rb;
                    AL_AND: e_vx = r_ra & r_rb;
                    AL_XOR: e_vx = r_ra ^ r_rb;
                    AL_ADD: begin
                        e_vx   = w_sum[7:0];
                        e_flag = w_sum[8];
                    end
                    AL_SUB: begin
                        e_vx   = r_ra - r_rb;
                        e_flag = r_ra > r_rb;
                    end
                    AL_SHR: begin
                        e_vx   = r_ra >> 1;
                        e_flag = r_ra[0];
                    end
                    AL_SBN: begin
                        e_vx   = r_rb - r_ra;
                        e_flag = r_rb > r_ra;
                    end
                    AL_SHL: begin
                        e_vx   = r_ra << 1;
                        e_flag = r_ra[7];
                    end
                    default: begin
                        e_vx_we = 1'b0;
                        e_fault = 1'b1;
                    end
                endcase
            end
            OPC_SNER: begin
                if (w_n != 4'd0) begin
                    e_fault = 1'b1;
                end else begin
                    e_pc = (r_ra != r_rb) ? w_skip : w_next;
                end
            end
            OPC_LDIX: begin
                e_i    = w_nnn;
                e_i_we = 1'b1;
            end
            // port a holds v0 for this group
            OPC_JPV0: e_pc = w_nnn + AW'(r_ra);
            OPC_RND: begin
                e_vx    = r_item.random_byte & w_kk;
                e_vx_we = 1'b1;
            end
            OPC_DRW: begin
            end
            OPC_KEY: begin
                if (w_kk == FN_SKP) begin
                    e_pc = w_key_dn ? w_skip : w_next;
                end else if (w_kk == FN_SKNP) begin
                    e_pc = w_key_dn ? w_next : w_skip;
                end else begin
                    e_fault = 1'b1;
                end
            end
            OPC_MISC: begin
                unique case (w_kk) inside
                    FN_GDT: begin
                        e_vx    = r_dt;
                        e_vx_we = 1'b1;
                    end
                    FN_WKEY: begin
                        if (r_item.keys == 16'd0) begin
                            e_wait = 1'b1;
                            e_pc   = r_pc;
                        end else begin
                            e_vx    = {4'd0, w_key_idx};
                            e_vx_we = 1'b1;
                        end
                    end
                    FN_SDT: e_dt_we = 1'b1;
                    FN_SST: e_st_we = 1'b1;
                    FN_ADDI: begin
                        e_i    = r_i + AW'(r_ra);
                        e_i_we = 1'b1;
                    end
                    FN_FONT: begin
                        e_i    = FONT_BASE + (AW'(r_ra[3:0]) << 2) + AW'(r_ra[3:0]);
                        e_i_we = 1'b1;
                    end
                    FN_BCD, FN_STR, FN_LDR: begin
                    end
                    default: e_fault = 1'b1;
                endcase
            end
        endcase
    end

    // sprite row placement with clipping at the right edge
    logic [7:0]              w_rev;
    logic [SCREEN_WIDTH-1:0] w_mask, w_row_old;
    logic [ROW_W:0]          w_row_sum;
    logic [ROW_W-1:0]        w_row, w_frame_ra;
    logic                    w_frame_re, w_spr_hit;

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            w_rev[c] = r_mem_q[7 - c];
        end
    end
    assign w_mask     = {{(SCREEN_WIDTH - 8){1'b0}}, w_rev} << r_ra[COL_W-1:0];
    assign w_row_old  = r_frame_v ? r_frame_q : '0;
    assign w_row_sum  = {1'b0, r_rb[ROW_W-1:0]} + (ROW_W + 1)'(r_cnt);
    assign w_row      = w_row_sum[ROW_W-1:0];
    assign w_spr_hit  = |(w_row_old & w_mask);
    assign w_frame_re = i_cmd.host_pix_rd | i_cmd.spr_rd;
    assign w_frame_ra = i_cmd.host_pix_rd ? r_item.addr[COL_W+ROW_W-1:COL_W] : w_row;

    // main memory port
    logic          w_mem_re, w_mem_we;
    logic [AW-1:0] w_mem_ra, w_mem_wa;
    logic [7:0]    w_mem_wd;

    assign w_mem_re = i_cmd.fetch_hi | i_cmd.fetch_lo | i_cmd.host_mem_rd |
                      i_cmd.spr_rd | i_cmd.ld_rd;
    always_comb begin
        if (i_cmd.fetch_hi) begin
            w_mem_ra = r_pc;
        end else if (i_cmd.fetch_lo) begin
            w_mem_ra = r_pc + 12'd1;
        end else if (i_cmd.host_mem_rd) begin
            w_mem_ra = r_item.addr;
        end else begin
            w_mem_ra = w_i_cnt;
        end
    end

    assign w_mem_we = i_cmd.init_wr | i_cmd.host_wr | i_cmd.bcd_wr | i_cmd.st_wr;
    always_comb begin
        if (i_cmd.init_wr) begin
            w_mem_wa = r_init;
            w_mem_wd = font_at(r_init);
        end else if (i_cmd.host_wr) begin
            w_mem_wa = r_item.addr;
            w_mem_wd = r_item.data;
        end else if (i_cmd.bcd_wr) begin
            w_mem_wa = w_i_cnt;
            w_mem_wd = bcd_digit(r_ra, r_cnt);
        end else begin
            w_mem_wa = w_i_cnt;
            w_mem_wd = r_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_mem_re) begin
            r_mem_q <= mem[w_mem_ra];
        end
    end

    // frame rows
    always_ff @(posedge i_clk) begin
        if (i_cmd.spr_wr) begin
            frame[w_row] <= w_row_old ^ w_mask;
        end
        if (w_frame_re) begin
            r_frame_q <= frame[w_frame_ra];
        end
    end

    // register file ports
    logic            w_rf_we, w_pa_re;
    logic [RI_W-1:0] w_rf_wa, w_pa_ra, w_pb_ra;
    logic [7:0]      w_rf_wd;

    always_comb begin
        w_rf_we = 1'b0;
        w_rf_wa = w_x;
        w_rf_wd = e_vx;
        if (i_cmd.exec && e_vx_we && !e_fault) begin
            w_rf_we = 1'b1;
        end else if (i_cmd.flag_wr) begin
            w_rf_we = 1'b1;
            w_rf_wa = RI_W'(NREGS - 1);
            w_rf_wd = {7'd0, r_flag};
        end else if (i_cmd.spr_end) begin
            w_rf_we = 1'b1;
            w_rf_wa = RI_W'(NREGS - 1);
            w_rf_wd = {7'd0, r_hit};
        end else if (i_cmd.ld_wr) begin
            w_rf_we = 1'b1;
            w_rf_wa = r_cnt;
            w_rf_wd = r_mem_q;
        end
    end

    assign w_pa_re = i_cmd.cap_op | i_cmd.st_rd;
    assign w_pa_ra = i_cmd.st_rd ? r_cnt : ((w_top == OPC_JPV0) ? '0 : w_x);
    assign w_pb_ra = r_mem_q[7:4];

    always_ff @(posedge i_clk) begin
        if (w_rf_we) begin
            regs[w_rf_wa] <= w_rf_wd;
        end
        if (w_pa_re) begin
            r_ra <= r_reg_vld[w_pa_ra] ? regs[w_pa_ra] : 8'd0;
        end
        if (i_cmd.cap_op) begin
            r_rb <= r_reg_vld[w_pb_ra] ? regs[w_pb_ra] : 8'd0;
        end
    end

    // return stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && e_push && !e_fault) begin
            stack[r_sc[SP_W-1:0]] <= w_next;
        end
    end

    // item capture and per-item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.fetch_lo) begin
            r_word[15:8] <= r_mem_q;
        end else if (i_cmd.cap_op) begin
            r_word[7:0] <= r_mem_q;
        end else if (i_cmd.latch) begin
            r_word <= '0;
        end
        if (i_cmd.latch) begin
            r_rd <= 8'd0;
        end else if (i_cmd.host_cap) begin
            if (r_item.op == OP_READ) begin
                r_rd <= r_mem_q;
            end else begin
                r_rd <= {7'd0, ~r_item.addr[AW-1] & w_row_old[r_item.addr[COL_W-1:0]]};
            end
        end
        if (i_cmd.exec) begin
            r_flag <= e_flag;
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= 4'd0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 4'd1;
        end
        if (w_frame_re) begin
            r_frame_v <= r_row_vld[w_frame_ra];
        end
    end

    // architectural control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PROG_START;
            r_i       <= '0;
            r_dt      <= 8'd0;
            r_st      <= 8'd0;
            r_halted  <= 1'b0;
            r_sc      <= '0;
            r_init    <= '0;
            r_row_vld <= '0;
            r_reg_vld <= '0;
            r_drew    <= 1'b0;
            r_wait    <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            if (i_cmd.init_wr) begin
                r_init <= r_init + 12'd1;
            end
            if (i_cmd.latch) begin
                r_drew <= 1'b0;
                r_wait <= 1'b0;
            end
            if (i_cmd.tick) begin
                if (r_st != 8'd0) begin
                    r_st <= r_st - 8'd1;
                end
                if (r_dt != 8'd0) begin
                    r_dt <= r_dt - 8'd1;
                end
            end
            if (w_rf_we) begin
                r_reg_vld[w_rf_wa] <= 1'b1;
            end
            if (i_cmd.exec) begin
                if (e_fault) begin
                    r_halted <= 1'b1;
                end else begin
                    r_pc   <= e_pc;
                    r_drew <= e_cls;
                    r_wait <= e_wait;
                    if (e_i_we) begin
                        r_i <= e_i;
                    end
                    if (e_dt_we) begin
                        r_dt <= r_ra;
                    end
                    if (e_st_we) begin
                        r_st <= r_ra;
                    end
                    if (e_push) begin
                        r_sc <= r_sc + SC_W'(1);
                    end else if (e_pop) begin
                        r_sc <= w_sc_dec;
                    end
                    if (e_cls) begin
                        r_row_vld <= '0;
                    end
                end
            end
            if (i_cmd.finish) begin
                r_pc <= w_next;
            end
            if (i_cmd.cnt_clr) begin
                r_hit <= 1'b0;
            end else if (i_cmd.spr_wr) begin
                r_hit <= r_hit | w_spr_hit;
                r_row_vld[w_row] <= 1'b1;
            end
            if (i_cmd.spr_end) begin
                r_drew <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.pc_now          <= r_pc;
            r_out.executed_opcode <= r_word;
            r_out.draw_request    <= r_drew;
            r_out.sound_on        <= (r_st != 8'd0);
            r_out.waiting_key     <= r_wait;
            r_out.fault           <= r_halted;
            r_out.read_data       <= r_rd;
        end
    end

    assign o_res = r_out;

    // status toward the sequencer
    assign o_stat.op        = r_item.op;
    assign o_stat.halted    = r_halted;
    assign o_stat.kind      = w_kind;
    assign o_stat.init_last = (r_init == '1);
    assign o_stat.spr_done  = (r_cnt == w_n) || w_row_sum[ROW_W];
    assign o_stat.last_x    = (r_cnt == w_x);
    assign o_stat.last_bcd  = (r_cnt == BCD_LAST);
    assign o_stat.sc        = r_sc;

endmodule

// ===== rtl/chip8_instruction_core.sv =====
// one item at a time; host writes, ticks, unused ops and halted executes go straight
// to the result, reads via a host read state, instructions via fetch, decode, execute
// and a flag state for flag writes; DRW adds a read and write pair per drawn row, BCD
// writes three digits, Fx55/Fx65 one pair per register through the single memory port;
// the next item is taken from the cycle after the result loads; after reset a clearing
// pass loads memory and font before any item; frame and registers clear at once
`include "chip8_instruction_core_defines.svh"

module chip8_instruction_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cic_in_if.sink    i_item,
    cic_out_if.source o_res
);
    import cic_pkg::*;

    t_cmd      w_cmd;
    t_stat     w_stat;
    t_in_item  w_item;
    t_out_item w_res;
    logic      w_in_ready, w_out_valid;

    // input beat payload
    assign w_item.op          = i_item.op;
    assign w_item.addr        = i_item.addr;
    assign w_item.data        = i_item.data;
    assign w_item.keys        = i_item.keys;
    assign w_item.random_byte = i_item.random_byte;
    assign i_item.ready       = w_in_ready;

    cic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cic_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (w_item),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    // result beat
    assign o_res.valid           = w_out_valid;
    assign o_res.pc_now          = w_res.pc_now;
    assign o_res.executed_opcode = w_res.executed_opcode;
    assign o_res.draw_request    = w_res.draw_request;
    assign o_res.sound_on        = w_res.sound_on;
    assign o_res.waiting_key     = w_res.waiting_key;
    assign o_res.fault           = w_res.fault;
    assign o_res.read_data       = w_res.read_data;

    // checks
    `CIC_ASSERT_NXT(a_one_item, i_item.valid && w_in_ready, !w_in_ready, "second item taken early")
    `CIC_ASSERT_NXT(a_halt_sticky, w_stat.halted, w_stat.halted, "halt flag dropped")
    `CIC_ASSERT_IMP(a_stack_bound, w_cmd.exec, w_stat.sc <= SC_W'(STACK_DEPTH), "stack overrun")

endmodule
